@@ sv/rhtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhtc_pkg
// Shared types, constants and the CRC-8 byte step for the humidity and
// temperature frame checker.
// ----------------------------------------------------------------------------
package rhtc_pkg;

  localparam int RawW   = 16;
  localparam int CrcW   = 8;
  localparam int SpanW  = 15;
  localparam int ProdW  = RawW + SpanW;
  localparam int QuotW  = 15;
  localparam int TempW  = 15;
  localparam int HumW   = 14;

  localparam logic [CrcW-1:0]  CRC_INIT     = 8'hFF;
  localparam logic [CrcW-1:0]  CRC_POLY_RST = 8'h31;
  localparam logic [SpanW-1:0] TEMP_SPAN    = 15'd17500;
  localparam logic [SpanW-1:0] HUM_SPAN     = 15'd10000;
  localparam logic [RawW-1:0]  RAW_FULL     = 16'hFFFF;
  localparam logic signed [TempW:0] TEMP_OFFSET = 16'sd4500;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic             valid;
    logic [QuotW-1:0] quot;
    logic             crc_bad;
  } rhtc_lane_res_t;

  // One byte of an MSB-first CRC-8 with implicit top bit.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [CrcW-1:0] b,
                                               input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < CrcW; k++) begin
      if (v[CrcW-1]) begin
        v = {v[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        v = {v[CrcW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

@@ sv/rh_temp_frame_check_convert.sv @@
// ----------------------------------------------------------------------------
// rh_temp_frame_check_convert
// Checks and converts one humidity/temperature sensor frame per beat.
// ----------------------------------------------------------------------------
// A frame is taken on any clock edge at which start is high; busy never rises,
// so a new frame may be presented every cycle. Each frame yields exactly one
// result beat, shown for a single cycle with done high, once the frame has
// passed the lane stages (the CRC runs over one byte per stage,
// alongside the constant multiply and then the divide by 65535) and then
// the merging register. The receiver cannot stall, so it must capture the
// result in the cycle that done is high. The temperature and humidity words
// travel in two identical lanes side by side. The CRC polynomial is written
// through the cfg port, which is always ready; write it only while no frame
// is in flight. A CRC mismatch does not stop conversion: the values are
// delivered unchanged and the flags are recomputed for every frame.
// ----------------------------------------------------------------------------
module rh_temp_frame_check_convert
  import rhtc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [RawW-1:0]         temp_raw,
  input  logic [CrcW-1:0]         temp_check,
  input  logic [RawW-1:0]         hum_raw,
  input  logic [CrcW-1:0]         hum_check,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CrcW-1:0]         cfg_data,
  output logic                    done,
  output logic signed [TempW-1:0] temp_centi,
  output logic [HumW-1:0]         hum_centi,
  output logic                    temp_crc_bad,
  output logic                    hum_crc_bad,
  output logic                    any_crc_bad
);

  logic           crc_poly;
  logic [CrcW-1:0] crc_poly_reg;
  logic           accept;
  rhtc_lane_res_t temp_res;
  rhtc_lane_res_t hum_res;

  // The pipeline takes a beat every cycle, so the block never pushes back.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign crc_poly  = cfg_valid & cfg_ready;

  // Polynomial register; a write lands when the cfg handshake completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly_reg <= CRC_POLY_RST;
    end else if (crc_poly) begin
      crc_poly_reg <= cfg_data;
    end
  end

  // Temperature lane.
  rhtc_lane u_temp_lane (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .raw      (temp_raw),
    .check    (temp_check),
    .poly     (crc_poly_reg),
    .span     (TEMP_SPAN),
    .res      (temp_res)
  );

  // Humidity lane.
  rhtc_lane u_hum_lane (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .raw      (hum_raw),
    .check    (hum_check),
    .poly     (crc_poly_reg),
    .span     (HUM_SPAN),
    .res      (hum_res)
  );

  // Merging stage drives the result beat.
  rhtc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .temp_res     (temp_res),
    .hum_res      (hum_res),
    .done         (done),
    .temp_centi   (temp_centi),
    .hum_centi    (hum_centi),
    .temp_crc_bad (temp_crc_bad),
    .hum_crc_bad  (hum_crc_bad),
    .any_crc_bad  (any_crc_bad)
  );

  // Both lanes must stay in step, or the merged beat would mix two frames.
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    temp_res.valid == hum_res.valid)
    else $error("lane valid bits disagree");

  // Every accepted frame gives a result beat once it has passed the lanes and the merging register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("result beat missing three cycles after start");

  // The combined flag always matches the two per-word flags.
  a_any_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (any_crc_bad == (temp_crc_bad | hum_crc_bad)))
    else $error("combined CRC flag inconsistent");

  // Converted values stay within their documented ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    done |-> (hum_centi <= HumW'(10000) && temp_centi >= -TempW'(4500)
              && temp_centi <= TempW'(13000)))
    else $error("converted value out of range");

endmodule

@@ sv/rhtc_lane.sv @@
// ----------------------------------------------------------------------------
// rhtc_lane
// One word of the frame: CRC-8 over its two bytes and the scaled value
// floor(span * raw / 65535), in two pipeline stages.
// ----------------------------------------------------------------------------
module rhtc_lane
  import rhtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RawW-1:0]      raw,
  input  logic [CrcW-1:0]      check,
  input  logic [CrcW-1:0]      poly,
  input  logic [SpanW-1:0]     span,
  output rhtc_lane_res_t       res
);

  logic             s1_valid;
  logic [ProdW-1:0] s1_prod;
  logic [CrcW-1:0]  s1_crc;
  logic [CrcW-1:0]  s1_lo;
  logic [CrcW-1:0]  s1_check;

  logic [QuotW-1:0] q_est;
  logic [RawW:0]    rem;
  logic [QuotW-1:0] quot_next;
  logic [CrcW-1:0]  crc_next;

  // Stage 1: constant-span multiply and the CRC over the high byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_prod  <= ProdW'(raw) * ProdW'(span);
    s1_crc   <= crc_byte(CRC_INIT, raw[RawW-1:CrcW], poly);
    s1_lo    <= raw[CrcW-1:0];
    s1_check <= check;
  end

  // Division by 65535: the estimate prod >> 16 is low by at most one, since
  // prod - 65535 * estimate is low half plus estimate, which stays below 2 * 65535.
  always_comb begin
    q_est     = s1_prod[ProdW-1:RawW];
    rem       = {1'b0, s1_prod[RawW-1:0]} + (RawW+1)'(q_est);
    quot_next = q_est + QuotW'(rem >= {1'b0, RAW_FULL});
    crc_next  = crc_byte(s1_crc, s1_lo, poly);
  end

  // Stage 2: quotient and check result.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s1_valid;
    end
    res.quot    <= quot_next;
    res.crc_bad <= (crc_next != s1_check);
  end

endmodule

@@ sv/rhtc_merge.sv @@
// ----------------------------------------------------------------------------
// rhtc_merge
// Combines the two lanes into one registered result beat: offsets the
// temperature, narrows the humidity and ORs the mismatch flags.
// ----------------------------------------------------------------------------
module rhtc_merge
  import rhtc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  rhtc_lane_res_t          temp_res,
  input  rhtc_lane_res_t          hum_res,
  output logic                    done,
  output logic signed [TempW-1:0] temp_centi,
  output logic [HumW-1:0]         hum_centi,
  output logic                    temp_crc_bad,
  output logic                    hum_crc_bad,
  output logic                    any_crc_bad
);

  logic signed [TempW:0] temp_wide;

  assign temp_wide = $signed({1'b0, temp_res.quot}) - TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= temp_res.valid;
    end
    temp_centi   <= temp_wide[TempW-1:0];
    hum_centi    <= hum_res.quot[HumW-1:0];
    temp_crc_bad <= temp_res.crc_bad;
    hum_crc_bad  <= hum_res.crc_bad;
    any_crc_bad  <= temp_res.crc_bad | hum_res.crc_bad;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: humidity/temperature frame checker testbench
// Drives sensor frames into rh_temp_frame_check_convert through its start/busy
// port and polynomial writes through the cfg channel. Every result beat is
// compared against a scoreboard of readings decoded in the testbench itself
// or typed into the directed table. A short directed table is followed by
// random phases under several polynomials.
// ----------------------------------------------------------------------------
module tb_top;
  import rhtc_pkg::*;

  // One decoded reading, as the block should present it on a done beat.
  typedef struct {
    logic signed [TempW-1:0] temp_centi;
    logic [HumW-1:0]         hum_centi;
    logic                    temp_bad;
    logic                    hum_bad;
    logic                    any_bad;
  } reading_t;

  // One row of the directed table. Where given is set the expected reading is
  // typed into the row; otherwise it is decoded by the testbench.
  typedef struct {
    logic [CrcW-1:0]         poly;
    logic [RawW-1:0]         traw;
    logic [CrcW-1:0]         tchk;
    logic [RawW-1:0]         hraw;
    logic [CrcW-1:0]         hchk;
    bit                      given;
    logic signed [TempW-1:0] t_exp;
    logic [HumW-1:0]         h_exp;
    bit                      tb_exp;
    bit                      hb_exp;
  } frame_row_t;

  localparam int DirRows     = 19;
  localparam int RandPhases  = 8;
  localparam int PhaseFrames = 182;
  localparam int GapPct      = 36;
  localparam int MaxGap      = 4;
  localparam int PrintCap    = 40;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [RawW-1:0]         temp_raw = '0;
  logic [CrcW-1:0]         temp_check = '0;
  logic [RawW-1:0]         hum_raw = '0;
  logic [CrcW-1:0]         hum_check = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CrcW-1:0]         cfg_data = '0;
  logic                    done;
  logic signed [TempW-1:0] temp_centi;
  logic [HumW-1:0]         hum_centi;
  logic                    temp_crc_bad;
  logic                    hum_crc_bad;
  logic                    any_crc_bad;

  // Readings still owed by the block, oldest first.
  reading_t        pending_readings[$];
  // The polynomial the block currently holds, as far as the testbench knows.
  logic [CrcW-1:0] poly_now = CRC_POLY_RST;
  int              mismatches = 0;
  int              beats_seen = 0;

  rh_temp_frame_check_convert DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .temp_raw     (temp_raw),
    .temp_check   (temp_check),
    .hum_raw      (hum_raw),
    .hum_check    (hum_check),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .temp_centi   (temp_centi),
    .hum_centi    (hum_centi),
    .temp_crc_bad (temp_crc_bad),
    .hum_crc_bad  (hum_crc_bad),
    .any_crc_bad  (any_crc_bad)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or never drains.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // The check byte is an MSB-first CRC-8 starting from all ones. Feeding the
  // sixteen data bits one at a time through the shift register gives the same
  // remainder as the byte-wise form, high byte first.
  function automatic logic [CrcW-1:0] sensor_crc8(input logic [RawW-1:0] word,
                                                  input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = 8'hFF;
    for (int i = RawW - 1; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ word[i];
      crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return crc;
  endfunction

  // Decodes one frame: floor divisions by full scale, then the temperature
  // offset. The products stay well inside 32 bits.
  function automatic reading_t decode_frame(input logic [RawW-1:0] traw,
                                            input logic [CrcW-1:0] tchk,
                                            input logic [RawW-1:0] hraw,
                                            input logic [CrcW-1:0] hchk,
                                            input logic [CrcW-1:0] poly);
    reading_t    r;
    int unsigned tq;
    int unsigned hq;
    int          tc;
    tq           = (32'(traw) * 32'd17500) / 32'd65535;
    hq           = (32'(hraw) * 32'd10000) / 32'd65535;
    tc           = int'(tq) - 4500;
    r.temp_centi = tc[TempW-1:0];
    r.hum_centi  = hq[HumW-1:0];
    r.temp_bad   = (sensor_crc8(traw, poly) != tchk);
    r.hum_bad    = (sensor_crc8(hraw, poly) != hchk);
    r.any_bad    = r.temp_bad | r.hum_bad;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("%0t ns: beat %0d: %s", $time, beats_seen, msg);
    end
  endtask

  // Presents one frame, possibly after a random gap, and holds it until the
  // block takes it. The expected reading joins the scoreboard on that edge.
  // Each further idle cycle is drawn with the same odds, so over a long run
  // about a third of the cycles carry no frame.
  task automatic send_frame(input logic [RawW-1:0] tr, input logic [CrcW-1:0] tc,
                            input logic [RawW-1:0] hr, input logic [CrcW-1:0] hc,
                            input reading_t want, input bit gaps);
    int gap;
    gap = 0;
    while (gaps && $urandom_range(99) < GapPct) begin
      gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    temp_raw   <= tr;
    temp_check <= tc;
    hum_raw    <= hr;
    hum_check  <= hc;
    do @(posedge clk); while (busy !== 1'b0);
    pending_readings.push_back(want);
  endtask

  // Stops issuing frames and waits for every owed reading. Each frame yields
  // exactly one result, so an empty scoreboard means the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_poly(input logic [CrcW-1:0] poly);
    if ($urandom_range(99) < GapPct) begin
      repeat ($urandom_range(MaxGap, 1)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_data  <= poly;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    poly_now  = poly;
  endtask

  // Result monitor. The receiver cannot stall, so every done beat is taken
  // at the edge that ends it and checked field by field against the oldest
  // owed reading.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && done !== 1'b0) begin
      beats_seen++;
      if (pending_readings.size() == 0) begin
        flag_mismatch("result beat with no frame outstanding");
      end else begin
        want = pending_readings.pop_front();
        if (temp_centi !== want.temp_centi) begin
          flag_mismatch($sformatf("temp_centi expected %0d got %0d",
                                  want.temp_centi, temp_centi));
        end
        if (hum_centi !== want.hum_centi) begin
          flag_mismatch($sformatf("hum_centi expected %0d got %0d",
                                  want.hum_centi, hum_centi));
        end
        if (temp_crc_bad !== want.temp_bad) begin
          flag_mismatch($sformatf("temp_crc_bad expected %b got %b",
                                  want.temp_bad, temp_crc_bad));
        end
        if (hum_crc_bad !== want.hum_bad) begin
          flag_mismatch($sformatf("hum_crc_bad expected %b got %b",
                                  want.hum_bad, hum_crc_bad));
        end
        if (any_crc_bad !== want.any_bad) begin
          flag_mismatch($sformatf("any_crc_bad expected %b got %b",
                                  want.any_bad, any_crc_bad));
        end
      end
    end
  end

  // Directed table. Under the reset polynomial the well-known word 0xBEEF
  // checks to 0x92. With a zero polynomial the remainder of any word is zero,
  // so a zero check byte is good and anything else is bad: that makes the
  // flags easy to type in beside the full-scale conversion extremes.
  frame_row_t dir_rows [DirRows] = '{
    '{8'h31, 16'hBEEF, 8'h92, 16'hBEEF, 8'h92, 1'b1, 15'sd8552, 14'd7458, 1'b0, 1'b0},
    '{8'h31, 16'hBEEF, 8'h93, 16'hBEEF, 8'h92, 1'b1, 15'sd8552, 14'd7458, 1'b1, 1'b0},
    '{8'h31, 16'hBEEF, 8'h92, 16'hBEEF, 8'h12, 1'b1, 15'sd8552, 14'd7458, 1'b0, 1'b1},
    '{8'h31, 16'hBEEF, 8'h00, 16'hBEEF, 8'hFF, 1'b1, 15'sd8552, 14'd7458, 1'b1, 1'b1},
    '{8'h31, 16'h0000, 8'h00, 16'hFFFF, 8'h00, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h31, 16'hFFFF, 8'hFF, 16'h0000, 8'hFF, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h31, 16'h8000, 8'h55, 16'h7FFF, 8'hAA, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h31, 16'h0001, 8'h01, 16'hFFFE, 8'hFE, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1, -15'sd4500, 14'd0, 1'b0, 1'b0},
    '{8'h00, 16'hFFFF, 8'h00, 16'hFFFF, 8'h00, 1'b1, 15'sd13000, 14'd10000, 1'b0, 1'b0},
    '{8'h00, 16'hFFFF, 8'hFF, 16'h0000, 8'h01, 1'b1, 15'sd13000, 14'd0, 1'b1, 1'b1},
    '{8'h00, 16'h0000, 8'h80, 16'hFFFF, 8'h00, 1'b1, -15'sd4500, 14'd10000, 1'b1, 1'b0},
    '{8'h00, 16'h1234, 8'h00, 16'hABCD, 8'h5A, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'hFF, 16'h0000, 8'h00, 16'h0000, 8'hFF, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'hFF, 16'hFFFF, 8'h5A, 16'hFFFF, 8'hA5, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'hFF, 16'h5555, 8'hAA, 16'hAAAA, 8'h55, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h07, 16'h4000, 8'h3C, 16'hC000, 8'hC3, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h07, 16'h6666, 8'h99, 16'h0F0F, 8'hF0, 1'b0, '0, '0, 1'b0, 1'b0},
    '{8'h31, 16'hBEEF, 8'h92, 16'hBEEF, 8'h92, 1'b1, 15'sd8552, 14'd7458, 1'b0, 1'b0}
  };

  // Polynomials for the random phases: the reset value (twice), both extremes,
  // a common alternative, and whatever the seed picks for the rest.
  function automatic logic [CrcW-1:0] phase_poly(input int p);
    case (p)
      0:       return CRC_POLY_RST;
      1:       return 8'hFF;
      2:       return 8'h00;
      3:       return 8'h07;
      6:       return CRC_POLY_RST;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A raw word: mostly uniform, now and then one of the awkward end points or the midpoint.
  function automatic logic [RawW-1:0] pick_raw();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2:       return 16'h0001;
        3:       return 16'hFFFE;
        default: return 16'h8000;
      endcase
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // A check byte: most frames arrive intact, some with a single flipped bit,
  // some with a byte of noise.
  function automatic logic [CrcW-1:0] pick_check(input logic [RawW-1:0] word,
                                                 input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] good;
    int              roll;
    good = sensor_crc8(word, poly);
    roll = $urandom_range(99);
    if (roll < 60) begin
      return good;
    end else if (roll < 80) begin
      return good ^ (8'h01 << $urandom_range(7));
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin : stimulus
    reading_t        want;
    frame_row_t      row;
    logic [RawW-1:0] tr;
    logic [RawW-1:0] hr;
    logic [CrcW-1:0] tc;
    logic [CrcW-1:0] hc;
    bit              gaps;

    // Synchronous reset first, then leave it alone for good.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A change of polynomial between rows is only made once
    // the block has delivered everything it owes.
    for (int i = 0; i < DirRows; i++) begin
      row = dir_rows[i];
      if (row.poly != poly_now) begin
        wait_drained();
        write_poly(row.poly);
      end
      if (row.given) begin
        want.temp_centi = row.t_exp;
        want.hum_centi  = row.h_exp;
        want.temp_bad   = row.tb_exp;
        want.hum_bad    = row.hb_exp;
        want.any_bad    = row.tb_exp | row.hb_exp;
      end else begin
        want = decode_frame(row.traw, row.tchk, row.hraw, row.hchk, poly_now);
      end
      send_frame(row.traw, row.tchk, row.hraw, row.hchk, want, 1'b1);
    end

    // Random phases, one polynomial each. The second phase runs with no gaps
    // at all so that frames are taken back to back on every cycle.
    for (int p = 0; p < RandPhases; p++) begin
      wait_drained();
      write_poly(phase_poly(p));
      gaps = (p != 1);
      for (int n = 0; n < PhaseFrames; n++) begin
        tr   = pick_raw();
        hr   = pick_raw();
        tc   = pick_check(tr, poly_now);
        hc   = pick_check(hr, poly_now);
        want = decode_frame(tr, tc, hr, hc, poly_now);
        send_frame(tr, tc, hr, hc, want, gaps);
      end
    end

    // Let the last beats arrive, then keep watching for strays.
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_readings.size() != 0) begin
      flag_mismatch($sformatf("%0d readings never delivered", pending_readings.size()));
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rhtc_pkg.sv
sv/rhtc_lane.sv
sv/rhtc_merge.sv
sv/rh_temp_frame_check_convert.sv
verif/tb_top.sv
